// ===== rtl/mfau_pkg.sv =====
// ----------------------------------------------------------------------------
// mfau_pkg
// Types, formats and constants shared by the activation unit pipeline.
// ----------------------------------------------------------------------------
package mfau_pkg;

  // Data format: signed Q4.12 at the ports, 30 fraction bits inside.
  localparam int unsigned DATA_W = 16;
  localparam int unsigned FRAC_W = 12;
  localparam int unsigned IFB    = 30;
  localparam int unsigned ISH    = IFB - FRAC_W;

  // Width of x scaled to the internal format, and of the angle register.
  localparam int unsigned XW  = DATA_W + ISH;
  localparam int unsigned QB  = (XW > 33) ? XW - 33 : 0;
  localparam int unsigned TRW = 34 + QB;
  // Width of the exponent argument, which holds up to 2|x| scaled.
  localparam int unsigned AW  = DATA_W + ISH + 2;

  localparam int unsigned EXP_TERMS  = 14;
  localparam int unsigned TRIG_TERMS = 8;
  localparam int unsigned NDIV_STEPS = 6;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned NUMW       = 62;

  localparam logic [30:0] ONE_Q        = 31'h4000_0000;
  localparam logic [29:0] LN2_Q        = 30'd744261118;
  localparam logic [30:0] HALF_PI_Q    = 31'd1686629713;
  localparam logic [29:0] QUARTER_PI_Q = 30'd843314856;
  localparam logic [32:0] TWO_PI_Q     = 33'd6746518852;
  localparam logic [23:0] LEAK_Q       = 24'd10737418;

  localparam logic signed [DATA_W-1:0] MAX_Y = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_Y = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_LINEAR  = 3'd0,
    KIND_TANH    = 3'd1,
    KIND_SIGMOID = 3'd2,
    KIND_RELU    = 3'd3,
    KIND_LEAKY   = 3'd4,
    KIND_SQUARE  = 3'd5,
    KIND_SINE    = 3'd6,
    KIND_COSINE  = 3'd7
  } kind_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    kind_e                    cmd;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     saturated;
  } out_item_t;

  // Everything one item carries down the pipeline.
  typedef struct packed {
    kind_e                    cmd;
    logic                     neg;
    logic signed [DATA_W-1:0] ys;
    logic                     ysat;
    // sine and cosine
    logic [TRW-1:0]           tr;
    logic [1:0]               q;
    logic                     swap;
    logic [29:0]              g;
    logic [29:0]              f2;
    logic [30:0]              ts;
    logic [30:0]              tc;
    logic [30:0]              tps;
    logic [30:0]              tpc;
    logic signed [31:0]       ss;
    logic signed [31:0]       sc;
    logic signed [31:0]       tv;
    // exponential
    logic [AW-1:0]            a;
    logic                     ez;
    logic [NDIV_STEPS-1:0]    n;
    logic [30:0]              term;
    logic [30:0]              tpe;
    logic signed [31:0]       esum;
    // quotient for tanh and sigmoid
    logic [NUMW-1:0]          num;
    logic [31:0]              den;
    logic [DIV_STEPS-1:0]     quo;
  } stage_t;

endpackage

// ===== rtl/mfau_div_pipe.sv =====
// ----------------------------------------------------------------------------
// mfau_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module mfau_div_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mfau_pkg::stage_t stage_i,
  output logic            valid_o,
  output mfau_pkg::stage_t stage_o
);
  import mfau_pkg::*;

  stage_t               stage_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DIV_STEPS-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int unsigned J = DIV_STEPS - 1 - s;
    stage_t         cur;
    stage_t         stage_d;
    logic [NUMW-1:0] thr;

    if (s == 0) begin : g_first
      assign cur = stage_i;
    end else begin : g_next
      assign cur = stage_q[s-1];
    end

    always_comb begin
      stage_d = cur;
      thr     = NUMW'(cur.den) << J;
      if (cur.num >= thr) begin
        stage_d.num    = cur.num - thr;
        stage_d.quo[J] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      stage_q[s] <= stage_d;
    end
  end

  assign valid_o = valid_q[DIV_STEPS-1];
  assign stage_o = stage_q[DIV_STEPS-1];

endmodule

// ===== rtl/multi_function_activation_unit_core.sv =====
// ----------------------------------------------------------------------------
// multi_function_activation_unit_core
// Q4.12 activation unit: identity, tanh, sigmoid, ReLU, leaky ReLU, square,
// sine and cosine.
// ----------------------------------------------------------------------------
// An item (x, cmd) is taken at each rising edge where start is high and busy
// is low. busy never rises, so a new item may enter in every cycle.
// Each item produces one result on result_o, marked by result_valid_o for
// exactly one cycle. Results leave in the order the items came in.
// The depth comes from the series evaluation: 2 angle reduction stages,
// 3 quadrant stages and 24 stages for the sine and cosine series, then
// 6 stages that split off multiples of ln 2, 42 stages for the exponential
// series (multiply, reciprocal multiply, correction per term) and a
// 31-stage divider for tanh and sigmoid. All kinds share the same latency.
// Throughput is one item per cycle.
// Reset clears the valid bits of every stage; items in flight are dropped.
// The receiver cannot hold results off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module multi_function_activation_unit_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mfau_pkg::in_item_t  act_i,
  output logic                result_valid_o,
  output mfau_pkg::out_item_t result_o
);
  import mfau_pkg::*;

  localparam int unsigned P_MOD  = 1;
  localparam int unsigned P_QUAD = P_MOD + QB + 1;
  localparam int unsigned P_SQ   = P_QUAD + 3;
  localparam int unsigned P_TT   = P_SQ + 1;
  localparam int unsigned P_TF   = P_TT + 3 * TRIG_TERMS;
  localparam int unsigned P_ND   = P_TF + 1;
  localparam int unsigned P_ET   = P_ND + NDIV_STEPS;
  localparam int unsigned P_EF   = P_ET + 3 * EXP_TERMS;

  localparam logic [TRW-1:0] TWO_PI_T  = TRW'(TWO_PI_Q);
  localparam logic [TRW-1:0] HALF_PI_T = TRW'(HALF_PI_Q);
  localparam logic signed [DATA_W+24:0] LK_RND = (DATA_W+25)'(1) << (IFB - 1);
  localparam logic [2*DATA_W:0] SQ_RND = (2*DATA_W+1)'(1) << (FRAC_W - 1);
  localparam logic signed [32:0] V_RND = 33'sd1 <<< (ISH - 1);

  stage_t    pipe_q [P_EF+1];
  logic      valid_q [P_EF+1];
  stage_t    entry_d;
  stage_t    dv_stage;
  logic      dv_valid;
  out_item_t result_d;
  out_item_t result_q;
  logic      result_valid_q;

  assign busy = 1'b0;

  // Entry stage: simple kinds are finished here and ride along to the end.
  always_comb begin
    logic signed [XW-1:0]          xq;
    logic [DATA_W:0]               xabs;
    logic signed [DATA_W+24:0]     lk;
    logic signed [2*DATA_W-1:0]    sxx;
    logic [2*DATA_W:0]             sqr;
    entry_d = '0;
    xq   = XW'(act_i.x) <<< ISH;
    xabs = act_i.x[DATA_W-1] ? -(DATA_W+1)'(act_i.x) : (DATA_W+1)'(act_i.x);
    lk   = act_i.x * $signed({1'b0, LEAK_Q}) + LK_RND;
    sxx  = act_i.x * act_i.x;
    sqr  = ({1'b0, sxx} + SQ_RND) >> FRAC_W;

    entry_d.cmd = act_i.cmd;
    entry_d.neg = act_i.x[DATA_W-1];
    entry_d.tr  = entry_d.neg ? TRW'(xq) + (TWO_PI_T << QB) : TRW'(xq);
    if (act_i.cmd == KIND_TANH) begin
      entry_d.a = AW'(xabs) << (ISH + 1);
    end else begin
      entry_d.a = AW'(xabs) << ISH;
    end
    entry_d.ez   = entry_d.a >= (AW'(32) << IFB);
    entry_d.term = ONE_Q;
    entry_d.esum = $signed({1'b0, ONE_Q});

    unique case (act_i.cmd)
      KIND_LINEAR: entry_d.ys = act_i.x;
      KIND_RELU:   entry_d.ys = entry_d.neg ? '0 : act_i.x;
      KIND_LEAKY:  entry_d.ys = entry_d.neg ? DATA_W'(lk >>> IFB) : act_i.x;
      KIND_SQUARE: begin
        if (sqr > (2*DATA_W+1)'(MAX_Y)) begin
          entry_d.ys   = MAX_Y;
          entry_d.ysat = 1'b1;
        end else begin
          entry_d.ys = DATA_W'(sqr);
        end
      end
      KIND_TANH, KIND_SIGMOID, KIND_SINE, KIND_COSINE: entry_d.ys = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= P_EF; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= start && !busy;
      for (int i = 1; i <= P_EF; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // Angle reduction to [0, 2pi).
  for (genvar m = 0; m <= QB; m++) begin : g_mod
    localparam int unsigned I = P_MOD + m;
    localparam int unsigned J = QB - m;
    stage_t mod_d;
    always_comb begin
      mod_d = pipe_q[I-1];
      if (pipe_q[I-1].tr >= (TWO_PI_T << J)) begin
        mod_d.tr = pipe_q[I-1].tr - (TWO_PI_T << J);
      end
    end
    always_ff @(posedge clk_i) pipe_q[I] <= mod_d;
  end

  // Quadrant and fold into [0, pi/4].
  if (1) begin : g_quad
    stage_t half_d, quad_d, fold_d;
    always_comb begin
      half_d = pipe_q[P_QUAD-1];
      if (half_d.tr >= (HALF_PI_T << 1)) begin
        half_d.tr   = half_d.tr - (HALF_PI_T << 1);
        half_d.q[1] = 1'b1;
      end
    end
    always_comb begin
      quad_d = pipe_q[P_QUAD];
      if (quad_d.tr >= HALF_PI_T) begin
        quad_d.tr   = quad_d.tr - HALF_PI_T;
        quad_d.q[0] = 1'b1;
      end
    end
    always_comb begin
      fold_d      = pipe_q[P_QUAD+1];
      fold_d.swap = fold_d.tr > TRW'(QUARTER_PI_Q);
      fold_d.g    = fold_d.swap ? 30'(HALF_PI_T - fold_d.tr) : 30'(fold_d.tr);
    end
    always_ff @(posedge clk_i) begin
      pipe_q[P_QUAD]   <= half_d;
      pipe_q[P_QUAD+1] <= quad_d;
      pipe_q[P_QUAD+2] <= fold_d;
    end
  end

  if (1) begin : g_sq
    stage_t      sq_d;
    logic [59:0] gg;
    always_comb begin
      sq_d    = pipe_q[P_SQ-1];
      gg      = sq_d.g * sq_d.g;
      sq_d.f2 = gg[59:30];
      sq_d.ts = {1'b0, sq_d.g};
      sq_d.tc = ONE_Q;
      sq_d.ss = $signed({2'b0, sq_d.g});
      sq_d.sc = $signed({1'b0, ONE_Q});
    end
    always_ff @(posedge clk_i) pipe_q[P_SQ] <= sq_d;
  end

  // Sine and cosine series: product, reciprocal estimate, correction.
  for (genvar k = 1; k <= TRIG_TERMS; k++) begin : g_trig
    localparam int unsigned B  = P_TT + 3 * (k - 1);
    localparam int unsigned DS = 2 * k * (2 * k + 1);
    localparam int unsigned DC = (2 * k - 1) * 2 * k;
    localparam logic [32:0] MS = 33'((64'd1 << 32) / DS);
    localparam logic [32:0] MC = 33'((64'd1 << 32) / DC);
    stage_t      prod_d, est_d, corr_d;
    logic [60:0] ps, pc;
    logic [63:0] es, ec;
    logic [30:0] rs, rc;
    always_comb begin
      prod_d     = pipe_q[B-1];
      ps         = prod_d.ts * prod_d.f2;
      pc         = prod_d.tc * prod_d.f2;
      prod_d.tps = 31'(ps >> IFB);
      prod_d.tpc = 31'(pc >> IFB);
    end
    always_comb begin
      est_d    = pipe_q[B];
      es       = est_d.tps * MS;
      ec       = est_d.tpc * MC;
      est_d.ts = 31'(es >> 32);
      est_d.tc = 31'(ec >> 32);
    end
    always_comb begin
      corr_d = pipe_q[B+1];
      rs = corr_d.tps - 31'(corr_d.ts * DS);
      rc = corr_d.tpc - 31'(corr_d.tc * DC);
      if (rs >= 31'(DS)) corr_d.ts = corr_d.ts + 31'd1;
      if (rc >= 31'(DC)) corr_d.tc = corr_d.tc + 31'd1;
      if (k % 2 == 1) begin
        corr_d.ss = corr_d.ss - $signed({1'b0, corr_d.ts});
        corr_d.sc = corr_d.sc - $signed({1'b0, corr_d.tc});
      end else begin
        corr_d.ss = corr_d.ss + $signed({1'b0, corr_d.ts});
        corr_d.sc = corr_d.sc + $signed({1'b0, corr_d.tc});
      end
    end
    always_ff @(posedge clk_i) begin
      pipe_q[B]   <= prod_d;
      pipe_q[B+1] <= est_d;
      pipe_q[B+2] <= corr_d;
    end
  end

  if (1) begin : g_trig_fin
    stage_t             tf_d;
    logic signed [31:0] sn, cs;
    logic [1:0]         qq;
    always_comb begin
      tf_d = pipe_q[P_TF-1];
      sn   = tf_d.swap ? tf_d.sc : tf_d.ss;
      cs   = tf_d.swap ? tf_d.ss : tf_d.sc;
      qq   = (tf_d.cmd == KIND_COSINE) ? tf_d.q + 2'd1 : tf_d.q;
      unique case (qq)
        2'd0: tf_d.tv = sn;
        2'd1: tf_d.tv = cs;
        2'd2: tf_d.tv = -sn;
        2'd3: tf_d.tv = -cs;
      endcase
    end
    always_ff @(posedge clk_i) pipe_q[P_TF] <= tf_d;
  end

  // Split the exponent argument into n*ln2 + r.
  for (genvar m = 0; m < NDIV_STEPS; m++) begin : g_ndiv
    localparam int unsigned I = P_ND + m;
    localparam int unsigned J = NDIV_STEPS - 1 - m;
    stage_t nd_d;
    always_comb begin
      nd_d = pipe_q[I-1];
      if (nd_d.a >= (AW'(LN2_Q) << J)) begin
        nd_d.a    = nd_d.a - (AW'(LN2_Q) << J);
        nd_d.n[J] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) pipe_q[I] <= nd_d;
  end

  for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_exp
    localparam int unsigned B  = P_ET + 3 * (k - 1);
    localparam logic [32:0] ME = 33'((64'd1 << 32) / k);
    stage_t      prod_d, est_d, corr_d;
    logic [60:0] pe;
    logic [63:0] ee;
    logic [30:0] re;
    always_comb begin
      prod_d     = pipe_q[B-1];
      pe         = prod_d.term * prod_d.a[29:0];
      prod_d.tpe = 31'(pe >> IFB);
    end
    always_comb begin
      est_d      = pipe_q[B];
      ee         = est_d.tpe * ME;
      est_d.term = 31'(ee >> 32);
    end
    always_comb begin
      corr_d = pipe_q[B+1];
      re = corr_d.tpe - 31'(corr_d.term * k);
      if (re >= 31'(k)) corr_d.term = corr_d.term + 31'd1;
      if (k % 2 == 1) begin
        corr_d.esum = corr_d.esum - $signed({1'b0, corr_d.term});
      end else begin
        corr_d.esum = corr_d.esum + $signed({1'b0, corr_d.term});
      end
    end
    always_ff @(posedge clk_i) begin
      pipe_q[B]   <= prod_d;
      pipe_q[B+1] <= est_d;
      pipe_q[B+2] <= corr_d;
    end
  end

  // Set up the quotient: sigmoid 2^60 / (1 + E), tanh (1 - E) * 2^30 / (1 + E).
  if (1) begin : g_exp_fin
    stage_t      ef_d;
    logic [30:0] e;
    always_comb begin
      ef_d     = pipe_q[P_EF-1];
      e        = ef_d.ez ? '0 : (31'(ef_d.esum) >> ef_d.n);
      ef_d.den = 32'(ONE_Q) + 32'(e);
      ef_d.quo = '0;
      if (ef_d.cmd == KIND_TANH) begin
        ef_d.num = NUMW'(ONE_Q - e) << IFB;
      end else begin
        ef_d.num = NUMW'(1) << (2 * IFB);
      end
    end
    always_ff @(posedge clk_i) pipe_q[P_EF] <= ef_d;
  end

  mfau_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[P_EF]),
    .stage_i (pipe_q[P_EF]),
    .valid_o (dv_valid),
    .stage_o (dv_stage)
  );

  // Final rounding to the port format and clipping.
  always_comb begin
    logic signed [31:0] v;
    logic signed [32:0] vr;
    v = '0;
    unique case (dv_stage.cmd)
      KIND_TANH: begin
        v = dv_stage.neg ? -$signed(32'(dv_stage.quo)) : $signed(32'(dv_stage.quo));
      end
      KIND_SIGMOID: begin
        v = dv_stage.neg ? $signed(32'(ONE_Q) - 32'(dv_stage.quo))
                         : $signed(32'(dv_stage.quo));
      end
      KIND_SINE, KIND_COSINE: v = dv_stage.tv;
      KIND_LINEAR, KIND_RELU, KIND_LEAKY, KIND_SQUARE: v = '0;
    endcase
    vr = (33'(v) + V_RND) >>> ISH;

    result_d.y         = dv_stage.ys;
    result_d.saturated = dv_stage.ysat;
    if (dv_stage.cmd == KIND_TANH || dv_stage.cmd == KIND_SIGMOID ||
        dv_stage.cmd == KIND_SINE || dv_stage.cmd == KIND_COSINE) begin
      if (vr > 33'(MAX_Y)) begin
        result_d.y         = MAX_Y;
        result_d.saturated = 1'b1;
      end else if (vr < 33'(MIN_Y)) begin
        result_d.y         = MIN_Y;
        result_d.saturated = 1'b1;
      end else begin
        result_d.y         = DATA_W'(vr);
        result_d.saturated = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== tb/tb_multi_function_activation_unit_core.sv =====
// ----------------------------------------------------------------------------
// tb_multi_function_activation_unit_core
// Self-checking testbench for the Q4.12 activation unit. Items go in through
// the start/busy handshake. An in-bench fixed-point model works out each
// activated value, and a monitor compares every result strobe against the
// oldest expected value.
// ----------------------------------------------------------------------------
module tb_multi_function_activation_unit_core;
  import mfau_pkg::*;

  localparam longint ONE      = 64'sd1 << 30;
  localparam longint LN2      = 64'sd744261118;
  localparam longint HALF_PI  = 64'sd1686629713;
  localparam longint QTR_PI   = HALF_PI / 2;
  localparam longint TWO_PI   = HALF_PI * 4;
  localparam longint LEAK     = 64'sd10737418;
  localparam int     MAX_CYCLES = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  act_i;
  logic      result_valid_o;
  out_item_t result_o;

  out_item_t expected_q[$];
  int        errors;
  int        cycles;
  int        idle_pct;

  multi_function_activation_unit_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .act_i         (act_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // exp(-a) with a split into multiples of ln 2 and a Taylor remainder.
  function automatic longint exp_neg(longint a);
    longint n, r, sum, term;
    if (a >= (64'sd32 << 30)) return 0;
    n = a / LN2;
    r = a - n * LN2;
    sum = ONE;
    term = ONE;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * r) >>> 30) / k;
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    return sum >>> n;
  endfunction

  function automatic void sincos_series(longint f, output longint sn, output longint cs);
    longint f2, ts, tc;
    f2 = (f * f) >>> 30;
    ts = f;
    tc = ONE;
    sn = f;
    cs = ONE;
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * f2) >>> 30) / (longint'(2 * k) * (2 * k + 1));
      tc = ((tc * f2) >>> 30) / (longint'(2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sn -= ts;
        cs -= tc;
      end else begin
        sn += ts;
        cs += tc;
      end
    end
  endfunction

  function automatic longint sin_cos(longint xq, bit want_cos);
    longint r, q, f, sn, cs;
    r = xq % TWO_PI;
    if (r < 0) r += TWO_PI;
    q = r / HALF_PI;
    if (q > 3) q = 3;
    f = r - q * HALF_PI;
    if (f > QTR_PI) sincos_series(HALF_PI - f, cs, sn);
    else sincos_series(f, sn, cs);
    if (want_cos) q = (q + 1) % 4;
    case (q)
      0: return sn;
      1: return cs;
      2: return -sn;
      default: return -cs;
    endcase
  endfunction

  function automatic out_item_t activate(in_item_t it);
    out_item_t res;
    longint x, xq, y, v, e, a;
    x = longint'(it.x);
    xq = x <<< 18;
    res.saturated = 1'b0;
    case (it.cmd)
      KIND_LINEAR: y = x;
      KIND_RELU:   y = (x > 0) ? x : 0;
      KIND_LEAKY:  y = (x >= 0) ? x : ((x * LEAK + (64'sd1 <<< 29)) >>> 30);
      KIND_SQUARE: y = (x * x + 2048) >>> 12;
      default: begin
        a = (xq < 0) ? -xq : xq;
        if (it.cmd == KIND_TANH) begin
          e = exp_neg(2 * a);
          v = ((ONE - e) <<< 30) / (ONE + e);
          if (xq < 0) v = -v;
        end else if (it.cmd == KIND_SIGMOID) begin
          e = exp_neg(a);
          v = (64'sd1 <<< 60) / (ONE + e);
          if (xq < 0) v = ONE - v;
        end else begin
          v = sin_cos(xq, it.cmd == KIND_COSINE);
        end
        y = (v + (64'sd1 <<< 17)) >>> 18;
      end
    endcase
    if (y > 32767) begin
      y = 32767;
      res.saturated = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      res.saturated = 1'b1;
    end
    res.y = y[15:0];
    return res;
  endfunction

  // Drives at the falling edge; the item goes in at the next rising edge
  // where busy is low. start stays high so the next item can follow at once.
  task automatic send_item(logic signed [15:0] x, kind_e k);
    bit taken;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    act_i.x = x;
    act_i.cmd = k;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    expected_q.push_back(activate(act_i));
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    start = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual y=%0d sat=%0b",
                 $time, result_o.y, result_o.saturated);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (result_o.y !== exp_item.y || result_o.saturated !== exp_item.saturated) begin
          $display("%0t: mismatch, expected y=%0d sat=%0b, actual y=%0d sat=%0b",
                   $time, exp_item.y, exp_item.saturated, result_o.y, result_o.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    for (int k = 0; k < 8; k++) begin
      send_item(16'sh7fff, kind_e'(k));
      send_item(-16'sh8000, kind_e'(k));
    end
    send_item(16'sd11585, KIND_SQUARE);
    send_item(16'sd11586, KIND_SQUARE);
    send_item(-16'sd11586, KIND_SQUARE);
    send_item(16'sd0, KIND_TANH);
    send_item(-16'sd1, KIND_LEAKY);
    send_item(16'sd1, KIND_SIGMOID);
    send_item(16'sd0, KIND_COSINE);
    send_item(16'sd6434, KIND_SINE);
  endtask

  task automatic test_random(int count, int pct);
    logic signed [15:0] x;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      // Most values stay where the curves bend; the rest span the full range.
      if ($urandom_range(3) == 0) x = 16'($urandom);
      else x = $signed(16'($urandom_range(32767))) - 16'sd16384;
      send_item(x, kind_e'($urandom_range(7)));
    end
    idle_pct = 0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    start = 1'b0;
    act_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(400, 0);
    test_random(250, 82);
    test_random(250, 8);
    test_random(250, 0);
    go_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
